/* design/client_subscription_table_unit_defines.svh */
// assertion macros shared by the client subscription table design
`ifndef CLIENT_SUBSCRIPTION_TABLE_UNIT_DEFINES_SVH
`define CLIENT_SUBSCRIPTION_TABLE_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cst_pkg.sv */
// types and constants of the client subscription table
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    localparam int OUT_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UNICAST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [15:0] TIMEOUT_RST = 16'd60;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PARAM     = 3'd1,
        ST_NOTINLIST = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4,
        ST_AGED      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_SKIP       = 2'd0,
        OP_AGE        = 2'd1,
        OP_CONNECT    = 2'd2,
        OP_DISCONNECT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SWEEP = 2'd1,
        S_DONE  = 2'd2
    } t_state;

    // request broadcast to every cell for the length of one sweep
    typedef struct packed {
        t_op          op;
        logic [31:0]  ip;
        logic [15:0]  port;
        logic [31:0]  now;
        logic [15:0]  timeout;
    } t_cmd;

    // flags carried by the wave from cell to cell
    typedef struct packed {
        logic live;
        logic matched;
        logic free_seen;
    } t_token;

endpackage

`default_nettype wire

/* design/cst_cell.sv */
// one slot of the subscription table, acting as the sweep wave passes
`timescale 1ns / 1ps
`default_nettype none

module cst_cell #(
    parameter int K     = 0,
    parameter int CNT_W = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  cst_pkg::t_cmd       i_cmd,
    input  cst_pkg::t_token     i_tok,
    input  wire  [CNT_W-1:0]    i_idx,
    input  wire  [CNT_W-1:0]    i_exp,
    input  wire                 i_alloc,
    output cst_pkg::t_token     o_tok,
    output logic [CNT_W-1:0]    o_idx,
    output logic [CNT_W-1:0]    o_exp
);
    import cst_pkg::*;

    logic        r_valid, n_valid;
    logic        r_cand, n_cand;
    logic [31:0] r_ip, n_ip;
    logic [15:0] r_port, n_port;
    logic [31:0] r_stamp, n_stamp;
    t_token      r_tok, n_tok;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_exp, n_exp;

    logic        hit;
    logic        aged;
    logic        first_free;
    logic [31:0] age;

    always_comb begin
        hit        = r_valid && (r_ip == i_cmd.ip) && (r_port == i_cmd.port);
        age        = i_cmd.now - r_stamp;
        aged       = r_valid && (age > 32'(i_cmd.timeout));
        first_free = !r_valid && !i_tok.free_seen;

        n_valid = r_valid;
        n_cand  = r_cand;
        n_ip    = r_ip;
        n_port  = r_port;
        n_stamp = r_stamp;
        n_tok   = i_tok;
        n_idx   = i_idx;
        n_exp   = i_exp;

        // commit of a new client into the first free slot found by the sweep
        if (i_alloc && r_cand) begin
            n_valid = 1'b1;
            n_cand  = 1'b0;
            n_ip    = i_cmd.ip;
            n_port  = i_cmd.port;
            n_stamp = i_cmd.now;
        end

        if (i_tok.live) begin
            n_cand = 1'b0;
            case (i_cmd.op)
                OP_CONNECT: begin
                    n_cand          = first_free;
                    n_tok.free_seen = i_tok.free_seen | ~r_valid;
                    if (hit) begin
                        n_stamp       = i_cmd.now;
                        n_tok.matched = 1'b1;
                        n_idx         = CNT_W'(K);
                    end else if (first_free && !i_tok.matched) begin
                        n_idx = CNT_W'(K);
                    end
                end
                OP_DISCONNECT: begin
                    if (hit) begin
                        n_valid       = 1'b0;
                        n_stamp       = '0;
                        n_tok.matched = 1'b1;
                        n_idx         = CNT_W'(K);
                    end
                end
                OP_AGE: begin
                    if (aged) begin
                        n_valid = 1'b0;
                        n_stamp = '0;
                        n_exp   = i_exp + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cand  <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cand  <= n_cand;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip              <= n_ip;
        r_port            <= n_port;
        r_stamp           <= n_stamp;
        r_idx             <= n_idx;
        r_exp             <= n_exp;
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;
    assign o_exp = r_exp;

endmodule

`default_nettype wire

/* design/client_subscription_table_unit.sv */
// top level of the client subscription table: control, chain of slot cells, result register
//
//   channel   direction  handshake               payload
//   request   in         i_valid / o_ready       i_command i_client_ip i_udp_port
//                                                i_connect_enable i_now_seconds
//   result    out        o_valid / i_ready       o_status o_slot_index o_active_count
//                                                o_expired_count
//   config    in         i_cfg_we (no wait)      i_cfg_idx i_cfg_data
//
// an accepted transfer is registered into r_launch, then the wave walks the chain of slots
// through the register of each cell, is caught at the chain end, is committed into the output
// register in the done state, and control returns to idle; no request is taken during a sweep
// a new request is taken while the previous result still waits in the output register
// the commit waits while that register is full and not being taken
// synchronous active-low reset empties every slot, clears the count and loads the
// register defaults (unicast on, timeout 60); slot addresses, ports and stamps are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "client_subscription_table_unit_defines.svh"

module client_subscription_table_unit #(
    parameter int ENTRIES = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request channel
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_command,
    input  wire  [31:0]                      i_client_ip,
    input  wire  [15:0]                      i_udp_port,
    input  wire  [7:0]                       i_connect_enable,
    input  wire  [31:0]                      i_now_seconds,
    // result channel
    output logic                             o_valid,
    input  wire                              i_ready,
    output cst_pkg::t_status                 o_status,
    output logic [cst_pkg::OUT_W-1:0]        o_slot_index,
    output logic [cst_pkg::OUT_W-1:0]        o_active_count,
    output logic [cst_pkg::OUT_W-1:0]        o_expired_count,
    // configuration writes
    input  wire                              i_cfg_we,
    input  wire  [cst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [cst_pkg::CFG_W-1:0]        i_cfg_data
);
    import cst_pkg::*;

    // wide enough to hold ENTRIES itself, the "no slot" index
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // configuration registers
    logic        r_unicast;
    logic [15:0] r_timeout;

    // control
    t_state      r_state, n_state;
    logic        r_launch;
    t_cmd        r_cmd;
    t_status     r_skip_status;
    logic        r_en_one;
    logic [CNT_W-1:0] r_count, n_count;

    // wave result caught at the end of the chain
    t_token           r_fin_tok;
    logic [CNT_W-1:0] r_fin_idx;
    logic [CNT_W-1:0] r_fin_exp;

    // output register
    logic             r_out_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_slot_idx;
    logic [CNT_W-1:0] r_active;
    logic [CNT_W-1:0] r_expired;

    // chain wiring, element k feeds cell k
    t_token           chain_tok [ENTRIES+1];
    logic [CNT_W-1:0] chain_idx [ENTRIES+1];
    logic [CNT_W-1:0] chain_exp [ENTRIES+1];

    logic             accept;
    logic             fire;
    logic             alloc;
    logic             need_alloc;
    t_status          res_status;
    logic [CNT_W-1:0] res_idx;
    logic [CNT_W-1:0] res_exp;
    t_cmd             cmd_in;
    t_status          skip_in;
    logic             wave_end;

    assign wave_end = chain_tok[ENTRIES].live;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unicast <= 1'b1;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UNICAST: r_unicast <= i_cfg_data[0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SWEEP;
            S_SWEEP: if (wave_end) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        fire    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_SWEEP: ;
            S_DONE:  fire = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign accept = i_valid && o_ready;

    // decode of the incoming request into a sweep operation
    always_comb begin
        cmd_in.ip      = i_client_ip;
        cmd_in.port    = i_udp_port;
        cmd_in.now     = i_now_seconds;
        cmd_in.timeout = r_timeout;
        skip_in        = ST_AGED;
        if (!i_command) begin
            cmd_in.op = r_unicast ? OP_AGE : OP_SKIP;
        end else if (!r_unicast) begin
            cmd_in.op = OP_SKIP;
            skip_in   = ST_INVALID;
        end else if (i_udp_port == 16'd0) begin
            cmd_in.op = OP_SKIP;
            skip_in   = ST_PARAM;
        end else if (i_connect_enable != 8'd0) begin
            cmd_in.op = OP_CONNECT;
        end else begin
            cmd_in.op = OP_DISCONNECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd         <= cmd_in;
            r_skip_status <= skip_in;
            r_en_one      <= (i_connect_enable == 8'd1);
        end
        if (wave_end) begin
            r_fin_tok <= chain_tok[ENTRIES];
            r_fin_idx <= chain_idx[ENTRIES];
            r_fin_exp <= chain_exp[ENTRIES];
        end
    end

    // head of the chain: a fresh wave with nothing seen yet
    assign chain_tok[0].live      = r_launch;
    assign chain_tok[0].matched   = 1'b0;
    assign chain_tok[0].free_seen = 1'b0;
    assign chain_idx[0]           = CNT_W'(ENTRIES);
    assign chain_exp[0]           = '0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        cst_cell #(
            .K     (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_tok   (chain_tok[k]),
            .i_idx   (chain_idx[k]),
            .i_exp   (chain_exp[k]),
            .i_alloc (alloc),
            .o_tok   (chain_tok[k+1]),
            .o_idx   (chain_idx[k+1]),
            .o_exp   (chain_exp[k+1])
        );
    end

    // result of the finished sweep
    always_comb begin
        res_status = r_skip_status;
        res_idx    = CNT_W'(ENTRIES);
        res_exp    = '0;
        need_alloc = 1'b0;
        n_count    = r_count;
        case (r_cmd.op)
            OP_AGE: begin
                res_status = ST_AGED;
                res_exp    = r_fin_exp;
                n_count    = r_count - r_fin_exp;
            end
            OP_CONNECT: begin
                if (r_fin_tok.matched) begin
                    res_status = ST_OK;
                    res_idx    = r_fin_idx;
                end else if (r_fin_tok.free_seen) begin
                    res_status = ST_OK;
                    res_idx    = r_fin_idx;
                    need_alloc = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                end else begin
                    // full table: plain enable reports full, any other reports not listed
                    res_status = r_en_one ? ST_FULL : ST_NOTINLIST;
                end
            end
            OP_DISCONNECT: begin
                if (r_fin_tok.matched) begin
                    res_status = ST_OK;
                    res_idx    = r_fin_idx;
                    n_count    = r_count - CNT_W'(1);
                end else begin
                    res_status = ST_NOTINLIST;
                end
            end
            default: ;
        endcase
    end

    assign alloc = fire && need_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status   <= res_status;
            r_slot_idx <= res_idx;
            r_active   <= n_count;
            r_expired  <= res_exp;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_slot_index    = OUT_W'(r_slot_idx);
    assign o_active_count  = OUT_W'(r_active);
    assign o_expired_count = OUT_W'(r_expired);

    `CST_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(ENTRIES), "occupied count beyond table size")
    `CST_ASSERT_IMPL(a_wave_in_sweep, wave_end, r_state == S_SWEEP, "wave left chain outside sweep")
    `CST_ASSERT_NEXT(a_accept_launch, accept, r_state == S_SWEEP && r_launch, "transfer did not launch")
    `CST_ASSERT_NEXT(a_fire_shows, fire, o_valid, "committed result not presented")

endmodule

`default_nettype wire
